### design/biq_pkg.sv
`default_nettype none

package biq_pkg;

	localparam int COEF_W     = 24;
	localparam int STATE_W    = 32;
	localparam int STATE_FRAC = 8;
	localparam int IDX_W      = 3;

	localparam logic [IDX_W-1:0] REG_B0 = 3'd0;
	localparam logic [IDX_W-1:0] REG_B1 = 3'd1;
	localparam logic [IDX_W-1:0] REG_B2 = 3'd2;
	localparam logic [IDX_W-1:0] REG_A1 = 3'd3;
	localparam logic [IDX_W-1:0] REG_A2 = 3'd4;
	localparam logic [IDX_W-1:0] REG_G0 = 3'd5;
	localparam logic [IDX_W-1:0] REG_G1 = 3'd6;

	localparam logic signed [COEF_W-1:0] RST_B0 = 24'sd1048576;
	localparam logic signed [COEF_W-1:0] RST_B1 = 24'sd2097152;
	localparam logic signed [COEF_W-1:0] RST_B2 = 24'sd1048576;
	localparam logic signed [COEF_W-1:0] RST_A1 = -24'sd1865031;
	localparam logic signed [COEF_W-1:0] RST_A2 = 24'sd839702;
	localparam logic signed [COEF_W-1:0] RST_G0 = 24'sd5812;
	localparam logic signed [COEF_W-1:0] RST_G1 = 24'sd1048576;

	typedef enum logic [2:0] {
		OP_GX,
		OP_A1,
		OP_A2,
		OP_B0,
		OP_B1,
		OP_B2,
		OP_G1
	} op_t;

	typedef enum logic [1:0] {
		SH_IN,
		SH_COEF,
		SH_OUT
	} shift_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_ACC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic   en;
		logic   clear;
		logic   sub;
		shift_t shift;
	} acc_ctl_t;

endpackage

`default_nettype wire

### design/biq_mul.sv
`default_nettype none

module biq_mul #(
	parameter int MCAND_W = 39
) (
	input  wire logic                                            clk,
	input  wire logic                                            arst_n,
	input  wire logic                                            start,
	input  wire logic signed [MCAND_W-1:0]                       mcand,
	input  wire logic signed [biq_pkg::COEF_W-1:0]               coef,
	output logic                                                 busy,
	output logic signed [MCAND_W+biq_pkg::COEF_W-1:0]            prod
);

	localparam int CW    = biq_pkg::COEF_W;
	localparam int PW    = MCAND_W + CW;
	localparam int CNT_W = $clog2(CW);

	logic                      busy_q;
	logic [CNT_W-1:0]          cnt_q;
	logic signed [MCAND_W-1:0] mcand_q;
	logic signed [PW-1:0]      prod_q;
	logic                      last;
	logic signed [MCAND_W:0]   m_ext;
	logic signed [MCAND_W:0]   addend;
	logic signed [MCAND_W:0]   sum;

	// One coefficient bit per cycle, LSB first; the sign bit carries negative weight.
	assign last  = (cnt_q == CNT_W'(CW - 1));
	assign m_ext = {mcand_q[MCAND_W-1], mcand_q};

	always_comb begin
		if (prod_q[0]) begin
			addend = last ? -m_ext : m_ext;
		end else begin
			addend = '0;
		end
		sum = {prod_q[PW-1], prod_q[PW-1:CW]} + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mcand;
			prod_q  <= {{MCAND_W{1'b0}}, coef};
		end else if (busy_q) begin
			prod_q <= {sum, prod_q[CW-1:1]};
		end
	end

	assign busy = busy_q;
	assign prod = prod_q;

endmodule

`default_nettype wire

### design/biq_acc.sv
`default_nettype none

module biq_acc #(
	parameter int PROD_W         = 63,
	parameter int COEF_FRAC_BITS = 20
) (
	input  wire logic                     clk,
	input  wire biq_pkg::acc_ctl_t        ctl,
	input  wire logic signed [PROD_W-1:0] prod,
	output logic signed [PROD_W:0]        acc
);

	localparam int AW     = PROD_W + 1;
	localparam int SH_IN  = COEF_FRAC_BITS - biq_pkg::STATE_FRAC;
	localparam int SH_CF  = COEF_FRAC_BITS;
	localparam int SH_OUT = COEF_FRAC_BITS + biq_pkg::STATE_FRAC;

	logic signed [PROD_W-1:0] sh_prod;
	logic                     rbit;
	logic signed [AW-1:0]     term;
	logic signed [AW-1:0]     base;
	logic signed [AW-1:0]     acc_q;

	// Round to nearest with ties up: floor of the shifted product plus the first dropped bit.
	always_comb begin
		unique case (ctl.shift)
			biq_pkg::SH_IN: begin
				sh_prod = prod >>> SH_IN;
				rbit    = prod[SH_IN-1];
			end
			biq_pkg::SH_OUT: begin
				sh_prod = prod >>> SH_OUT;
				rbit    = prod[SH_OUT-1];
			end
			default: begin
				sh_prod = prod >>> SH_CF;
				rbit    = prod[SH_CF-1];
			end
		endcase
		term = {sh_prod[PROD_W-1], sh_prod} + {{(AW-1){1'b0}}, rbit};
		base = ctl.clear ? '0 : acc_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc_q <= ctl.sub ? (base - term) : (base + term);
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

### design/biquad_iir_filter_top.sv
// Biquad IIR section, direct form II, computed with one bit-serial multiplier.
// Each of the seven products takes a load, one shift-add per coefficient bit, a step to
// see the multiplier finish and a round-and-accumulate step. A new sample is taken
// only in the idle state, once the last result has gone to the output register, which
// waits while an earlier result is still pending.
// Reset (arst_n low) restores the default coefficients and clears the delay line.
`default_nettype none

module biquad_iir_filter_top #(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int COEF_FRAC_BITS = 20
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [biq_pkg::IDX_W-1:0]        cfg_index,
	input  wire logic [biq_pkg::COEF_W-1:0]       cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic signed [SAMPLE_WIDTH-1:0]   sample_in,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]        sample_out,
	output logic                                  clipped
);

	localparam int CW    = biq_pkg::COEF_W;
	localparam int SW_ST = biq_pkg::STATE_W;
	localparam int SUM_W = SW_ST + CW - COEF_FRAC_BITS + 3;
	localparam int MW    = (SUM_W > SW_ST) ? SUM_W : SW_ST;
	localparam int PW    = MW + CW;
	localparam int AW    = PW + 1;

	localparam logic signed [AW-1:0] W_MAX = (AW'(1) <<< (SW_ST - 1)) - AW'(1);
	localparam logic signed [AW-1:0] W_MIN = -W_MAX - AW'(1);
	localparam logic signed [AW-1:0] Y_MAX = (AW'(1) <<< (SAMPLE_WIDTH - 1)) - AW'(1);
	localparam logic signed [AW-1:0] Y_MIN = -Y_MAX - AW'(1);

	logic signed [CW-1:0] b0_q, b1_q, b2_q, a1_q, a2_q, g0_q, g1_q;

	biq_pkg::state_t state_q, state_d;
	biq_pkg::op_t    op_q, op_d;
	biq_pkg::acc_ctl_t acc_ctl;

	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic signed [SW_ST-1:0]        w1_q, w2_q, w_q;
	logic signed [SW_ST-1:0]        w_sat;
	logic signed [SAMPLE_WIDTH-1:0] y_sat;
	logic                           y_clip;

	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_out_q;
	logic                           clipped_q;

	logic                  accept;
	logic                  mul_start;
	logic                  mul_busy;
	logic                  w_we;
	logic                  out_we;
	logic signed [MW-1:0]  mcand;
	logic signed [CW-1:0]  coef;
	logic signed [PW-1:0]  prod;
	logic signed [AW-1:0]  acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q <= biq_pkg::RST_B0;
			b1_q <= biq_pkg::RST_B1;
			b2_q <= biq_pkg::RST_B2;
			a1_q <= biq_pkg::RST_A1;
			a2_q <= biq_pkg::RST_A2;
			g0_q <= biq_pkg::RST_G0;
			g1_q <= biq_pkg::RST_G1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				biq_pkg::REG_B0: b0_q <= cfg_data;
				biq_pkg::REG_B1: b1_q <= cfg_data;
				biq_pkg::REG_B2: b2_q <= cfg_data;
				biq_pkg::REG_A1: a1_q <= cfg_data;
				biq_pkg::REG_A2: a2_q <= cfg_data;
				biq_pkg::REG_G0: g0_q <= cfg_data;
				biq_pkg::REG_G1: g1_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (acc > W_MAX) begin
			w_sat = SW_ST'(W_MAX);
		end else if (acc < W_MIN) begin
			w_sat = SW_ST'(W_MIN);
		end else begin
			w_sat = acc[SW_ST-1:0];
		end
		y_clip = (acc > Y_MAX) || (acc < Y_MIN);
		if (acc > Y_MAX) begin
			y_sat = SAMPLE_WIDTH'(Y_MAX);
		end else if (acc < Y_MIN) begin
			y_sat = SAMPLE_WIDTH'(Y_MIN);
		end else begin
			y_sat = acc[SAMPLE_WIDTH-1:0];
		end
	end

	always_comb begin
		unique case (op_q)
			biq_pkg::OP_GX: begin
				mcand = MW'(x_q);
				coef  = g0_q;
			end
			biq_pkg::OP_A1: begin
				mcand = MW'(w1_q);
				coef  = a1_q;
			end
			biq_pkg::OP_A2: begin
				mcand = MW'(w2_q);
				coef  = a2_q;
			end
			biq_pkg::OP_B0: begin
				mcand = MW'(w_sat);
				coef  = b0_q;
			end
			biq_pkg::OP_B1: begin
				mcand = MW'(w1_q);
				coef  = b1_q;
			end
			biq_pkg::OP_B2: begin
				mcand = MW'(w2_q);
				coef  = b2_q;
			end
			biq_pkg::OP_G1: begin
				mcand = acc[MW-1:0];
				coef  = g1_q;
			end
			default: begin
				mcand = '0;
				coef  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= biq_pkg::ST_IDLE;
			op_q    <= biq_pkg::OP_GX;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		op_d          = op_q;
		in_ready      = 1'b0;
		mul_start     = 1'b0;
		w_we          = 1'b0;
		out_we        = 1'b0;
		acc_ctl.en    = 1'b0;
		acc_ctl.clear = (op_q == biq_pkg::OP_GX) || (op_q == biq_pkg::OP_B0) ||
			(op_q == biq_pkg::OP_G1);
		acc_ctl.sub   = (op_q == biq_pkg::OP_A1) || (op_q == biq_pkg::OP_A2);
		if (op_q == biq_pkg::OP_GX) begin
			acc_ctl.shift = biq_pkg::SH_IN;
		end else if (op_q == biq_pkg::OP_G1) begin
			acc_ctl.shift = biq_pkg::SH_OUT;
		end else begin
			acc_ctl.shift = biq_pkg::SH_COEF;
		end
		unique case (state_q)
			biq_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op_d    = biq_pkg::OP_GX;
					state_d = biq_pkg::ST_LOAD;
				end
			end
			biq_pkg::ST_LOAD: begin
				mul_start = 1'b1;
				w_we      = (op_q == biq_pkg::OP_B0);
				state_d   = biq_pkg::ST_MUL;
			end
			biq_pkg::ST_MUL: begin
				if (!mul_busy) begin
					state_d = biq_pkg::ST_ACC;
				end
			end
			biq_pkg::ST_ACC: begin
				acc_ctl.en = 1'b1;
				if (op_q == biq_pkg::OP_G1) begin
					state_d = biq_pkg::ST_DONE;
				end else begin
					op_d    = biq_pkg::op_t'(op_q + 3'd1);
					state_d = biq_pkg::ST_LOAD;
				end
			end
			biq_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_we  = 1'b1;
					state_d = biq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = biq_pkg::ST_IDLE;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= sample_in;
		end
		if (w_we) begin
			w_q <= w_sat;
		end
		if (out_we) begin
			sample_out_q <= y_sat;
			clipped_q    <= y_clip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w1_q        <= '0;
			w2_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_we) begin
				w1_q        <= w_q;
				w2_q        <= w1_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	biq_mul #(
		.MCAND_W(MW)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.mcand (mcand),
		.coef  (coef),
		.busy  (mul_busy),
		.prod  (prod)
	);

	biq_acc #(
		.PROD_W        (PW),
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_acc (
		.clk (clk),
		.ctl (acc_ctl),
		.prod(prod),
		.acc (acc)
	);

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign clipped    = clipped_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_we |-> (!out_valid_q || out_ready))
		else $error("pending result overwritten");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_busy)
		else $error("multiplier started while busy");

	a_acc_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		acc_ctl.en |-> (!mul_busy && $past(state_q) == biq_pkg::ST_MUL))
		else $error("accumulate without finished product");

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |=> mul_busy)
		else $error("multiplier did not start");
`endif

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int SW = 16;
	localparam int CFB = 20;
	localparam int CW = biq_pkg::COEF_W;
	localparam int IW = biq_pkg::IDX_W;
	localparam int HOLDOFF_CYCLES = 1000;
	localparam int STUCK_LIMIT = 5000;
	localparam logic [IW-1:0] REG_UNUSED = 3'd7;
	localparam longint W_MAX = (longint'(1) <<< (biq_pkg::STATE_W - 1)) - 1;
	localparam longint W_MIN = -(longint'(1) <<< (biq_pkg::STATE_W - 1));
	localparam longint Y_MAX = (longint'(1) <<< (SW - 1)) - 1;
	localparam longint Y_MIN = -(longint'(1) <<< (SW - 1));

	typedef struct {
		logic signed [SW-1:0] y;
		logic                 clip;
	} filt_out_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b1;
	logic                     cfg_we = 1'b0;
	logic [IW-1:0]            cfg_index = '0;
	logic [CW-1:0]            cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic signed [SW-1:0]     sample_in = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [SW-1:0]     sample_out;
	logic                     clipped;

	logic signed [SW-1:0]     samples_to_send[$];
	filt_out_t                predicted_outputs[$];
	longint                   coef[7];
	longint                   delay_w1;
	longint                   delay_w2;
	int                       mismatches = 0;
	int                       send_idle_pct = 0;
	int                       recv_idle_pct = 0;
	int                       holdoffs_requested = 0;
	int                       holdoffs_done = 0;
	int                       holdoff_left = 0;
	int                       stuck_cycles = 0;

	biquad_iir_filter_top #(
		.SAMPLE_WIDTH(SW),
		.COEF_FRAC_BITS(CFB)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_in(sample_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample_out(sample_out),
		.clipped(clipped)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint round_off(longint v, int sh);
		return (v + (longint'(1) <<< (sh - 1))) >>> sh;
	endfunction

	function automatic filt_out_t biquad_predict(logic signed [SW-1:0] x);
		longint w;
		longint s;
		longint y;
		filt_out_t r;
		w = round_off(coef[biq_pkg::REG_G0] * longint'(x), CFB - biq_pkg::STATE_FRAC)
			- round_off(coef[biq_pkg::REG_A1] * delay_w1, CFB)
			- round_off(coef[biq_pkg::REG_A2] * delay_w2, CFB);
		if (w > W_MAX) begin
			w = W_MAX;
		end else if (w < W_MIN) begin
			w = W_MIN;
		end
		s = round_off(coef[biq_pkg::REG_B0] * w, CFB)
			+ round_off(coef[biq_pkg::REG_B1] * delay_w1, CFB)
			+ round_off(coef[biq_pkg::REG_B2] * delay_w2, CFB);
		y = round_off(s * coef[biq_pkg::REG_G1], CFB + biq_pkg::STATE_FRAC);
		r.clip = 1'b0;
		if (y > Y_MAX) begin
			y = Y_MAX;
			r.clip = 1'b1;
		end else if (y < Y_MIN) begin
			y = Y_MIN;
			r.clip = 1'b1;
		end
		r.y = y[SW-1:0];
		delay_w2 = delay_w1;
		delay_w1 = w;
		return r;
	endfunction

	function automatic logic [CW-1:0] pick_coef(logic [CW-1:0] dflt, int span);
		int v;
		v = int'($urandom_range(2 * span)) - span;
		case ($urandom_range(7))
			0: return CW'($urandom);
			1: return {1'b0, {(CW-1){1'b1}}};
			2: return {1'b1, {(CW-1){1'b0}}};
			3: return dflt;
			default: return v[CW-1:0];
		endcase
	endfunction

	function automatic logic [SW-1:0] rand_sample();
		int v;
		v = int'($urandom_range(512)) - 256;
		case ($urandom_range(9))
			0: return {1'b0, {(SW-1){1'b1}}};
			1: return {1'b1, {(SW-1){1'b0}}};
			2, 3: return v[SW-1:0];
			default: return SW'($urandom);
		endcase
	endfunction

	task automatic write_reg(logic [IW-1:0] idx, logic [CW-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx <= biq_pkg::REG_G1) begin
			coef[idx] = longint'($signed(data));
		end
	endtask

	task automatic write_coefs(logic [CW-1:0] b0, logic [CW-1:0] b1,
			logic [CW-1:0] b2, logic [CW-1:0] a1, logic [CW-1:0] a2,
			logic [CW-1:0] g0, logic [CW-1:0] g1);
		write_reg(biq_pkg::REG_B0, b0);
		write_reg(biq_pkg::REG_B1, b1);
		write_reg(REG_UNUSED, CW'($urandom));
		write_reg(biq_pkg::REG_B2, b2);
		write_reg(biq_pkg::REG_A1, a1);
		write_reg(biq_pkg::REG_A2, a2);
		write_reg(biq_pkg::REG_G0, g0);
		write_reg(biq_pkg::REG_G1, g1);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		do begin
			@(posedge clk);
		end while (samples_to_send.size() != 0 || in_valid || predicted_outputs.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) begin
				predicted_outputs.push_back(biquad_predict(sample_in));
			end
			if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				sample_in <= samples_to_send.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (holdoffs_requested != holdoffs_done) begin
			holdoffs_done <= holdoffs_done + 1;
			holdoff_left <= HOLDOFF_CYCLES;
			out_ready <= 1'b0;
		end else if (holdoff_left > 0) begin
			holdoff_left <= holdoff_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin : result_check
		filt_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (predicted_outputs.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected transfer, expected none, actual sample_out %0d clipped %0b",
					$time, sample_out, clipped);
			end else begin
				want = predicted_outputs.pop_front();
				if (sample_out !== want.y) begin
					mismatches++;
					$display("%0t: sample_out expected %0d actual %0d", $time, want.y, sample_out);
				end
				if (clipped !== want.clip) begin
					mismatches++;
					$display("%0t: clipped expected %0b actual %0b", $time, want.clip, clipped);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("biquad_iir_filter_top test failed");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		coef[biq_pkg::REG_B0] = longint'(biq_pkg::RST_B0);
		coef[biq_pkg::REG_B1] = longint'(biq_pkg::RST_B1);
		coef[biq_pkg::REG_B2] = longint'(biq_pkg::RST_B2);
		coef[biq_pkg::REG_A1] = longint'(biq_pkg::RST_A1);
		coef[biq_pkg::REG_A2] = longint'(biq_pkg::RST_A2);
		coef[biq_pkg::REG_G0] = longint'(biq_pkg::RST_G0);
		coef[biq_pkg::REG_G1] = longint'(biq_pkg::RST_G1);
		delay_w1 = 0;
		delay_w2 = 0;
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		samples_to_send = '{16'sh7fff, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh0001, 16'sh7fff};
		wait_idle();

		// Strong positive feedback drives the state into saturation and the output into clipping.
		write_coefs(24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff,
			24'h7fffff, 24'h7fffff);
		repeat (5) samples_to_send.push_back(16'sh7fff);
		repeat (5) samples_to_send.push_back(-16'sh8000);
		wait_idle();

		write_coefs(24'h800000, 24'h000000, 24'h7fffff, 24'h7fffff, 24'h800000,
			24'h800000, 24'h800000);
		repeat (3) samples_to_send.push_back(-16'sh8000);
		repeat (3) samples_to_send.push_back(16'sh7fff);
		wait_idle();

		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 14 : (mode == 1) ? 87 : 0;
			recv_idle_pct = (mode == 0) ? 87 : (mode == 1) ? 14 : 0;
			for (int cfg_round = 0; cfg_round < 3; cfg_round++) begin
				write_coefs(pick_coef(biq_pkg::RST_B0, 2097152),
					pick_coef(biq_pkg::RST_B1, 2097152),
					pick_coef(biq_pkg::RST_B2, 2097152),
					pick_coef(biq_pkg::RST_A1, 2097152),
					pick_coef(biq_pkg::RST_A2, 900000),
					pick_coef(biq_pkg::RST_G0, 65536),
					pick_coef(biq_pkg::RST_G1, 2097152));
				repeat (50) samples_to_send.push_back(rand_sample());
				if (cfg_round == 1) begin
					holdoffs_requested++;
				end
				wait_idle();
				repeat (50) samples_to_send.push_back(rand_sample());
				wait_idle();
			end
		end

		repeat (200) @(posedge clk);
		if (mismatches == 0) begin
			$display("biquad_iir_filter_top test passed");
		end else begin
			$display("biquad_iir_filter_top test failed");
		end
		$finish;
	end

endmodule
